// ===== sv/bfws_pkg.sv =====
// Package for the box filter window sum block.
// Holds field widths, register indexes and reset values; no dependencies.
package bfws_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RADIUS_W  = 5;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd1;
    localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd1024;

endpackage

// ===== sv/bfws_if.sv =====
// Stream interfaces of the box filter window sum block.
// Depends on bfws_pkg for the sample width.
interface bfws_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [bfws_pkg::SAMPLE_W-1:0] sample;
    modport source (output valid, func, sample, input ready);
    modport sink   (input valid, func, sample, output ready);
endinterface

interface bfws_out_if #(parameter int SUM_W = 27);
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] box_sum;
    logic                    frame_end;
    modport source (output valid, box_sum, frame_end, input ready);
    modport sink   (input valid, box_sum, frame_end, output ready);
endinterface

// ===== sv/box_filter_window_sum_core.sv =====
// Box filter window sum: takes one sample per clock in raster order while ready is
// high and gives the clipped (2r+1)x(2r+1) window sum for each position. Result k
// leaves after the transaction carrying item k + r*width + r has passed the stage 1
// registers and the output buffer; drain items push the frame tail out. Sustained
// rate is one item per clock while ready is high, set by the read-modify-write of
// the column sum memory and the row sum ring memory, both read in the accept cycle
// and written in the next cycle with forwarding for back-to-back hits. Input ready
// drops only while the four-entry output buffer is nearly full. No clearing pass
// after reset: every memory entry is written within a frame before it is read.
// Write configuration only between frames. Depends on bfws_pkg and bfws_if.
module box_filter_window_sum_core #(
    parameter int MAX_RADIUS = 16,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bfws_in_if.sink                            samples,
    bfws_out_if.source                         results,
    input  logic                               cfg_we,
    input  logic [bfws_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bfws_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int SW       = bfws_pkg::SAMPLE_W;
    localparam int HW       = SW + $clog2(2*MAX_RADIUS+1);
    localparam int SUM_W    = SW + $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1));
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WV_W     = $clog2(MAX_WIDTH+1);
    localparam int HV_W     = $clog2(MAX_HEIGHT+1);
    localparam int R_W      = $clog2(MAX_RADIUS+1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT+MAX_RADIUS+1) + 1;
    localparam int SLOT_W   = $clog2(2*MAX_RADIUS+1);
    localparam int HIST_N   = 2*MAX_RADIUS+1;
    localparam int TAP_W    = $clog2(2*MAX_RADIUS+2);
    localparam int CI_W     = $clog2(MAX_WIDTH+2*MAX_RADIUS+2) + 1;
    localparam int ADDR_W   = SLOT_W + COL_W;
    localparam int ST_DEPTH = (2*MAX_RADIUS+1) * (2**COL_W);
    localparam int FIFO_N   = 4;
    localparam int FP_W     = $clog2(FIFO_N);
    localparam int FC_W     = $clog2(FIFO_N+1);

    // ---------------- configuration ----------------
    logic [bfws_pkg::RADIUS_W-1:0] radius_reg;
    logic [bfws_pkg::DIM_W-1:0]    fwidth_reg, fheight_reg;
    logic [R_W-1:0]                r_eff;
    logic [WV_W-1:0]               w_eff;
    logic [HV_W-1:0]               h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= bfws_pkg::RADIUS_RST;
            fwidth_reg  <= bfws_pkg::WIDTH_RST;
            fheight_reg <= bfws_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bfws_pkg::REG_RADIUS: radius_reg  <= cfg_data[bfws_pkg::RADIUS_W-1:0];
                bfws_pkg::REG_WIDTH:  fwidth_reg  <= cfg_data;
                bfws_pkg::REG_HEIGHT: fheight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp registers to legal ranges
    always_comb
    begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
        if (fwidth_reg == '0)
            w_eff = WV_W'(1);
        else if (32'(fwidth_reg) > MAX_WIDTH)
            w_eff = WV_W'(MAX_WIDTH);
        else
            w_eff = WV_W'(fwidth_reg);
        if (fheight_reg == '0)
            h_eff = HV_W'(1);
        else if (32'(fheight_reg) > MAX_HEIGHT)
            h_eff = HV_W'(MAX_HEIGHT);
        else
            h_eff = HV_W'(fheight_reg);
    end

    logic cfg_hit;
    assign cfg_hit = cfg_we && (cfg_addr == bfws_pkg::REG_RADIUS ||
                                cfg_addr == bfws_pkg::REG_WIDTH  ||
                                cfg_addr == bfws_pkg::REG_HEIGHT);

    // ---------------- counters ----------------
    // p: incoming position column; t = p - r: position whose row sum is formed
    logic [COL_W-1:0]  pcol_reg, pcol_next;
    logic [R_W-1:0]    lead_reg, lead_next;
    logic [COL_W-1:0]  tcol_reg, tcol_next;
    logic [ROW_W-1:0]  trow_reg, trow_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic accept, t_on, out_en, last, add_en, sub_en, first_row;
    logic [ROW_W-1:0] r_x, h_x;
    logic [WV_W-1:0]  w_m1;
    logic [FC_W-1:0]  cnt_reg;
    logic             s1_valid_reg, s1_out_reg;

    assign samples.ready = ({1'b0, cnt_reg} + (FC_W+1)'(s1_valid_reg & s1_out_reg))
                           <= (FC_W+1)'(FIFO_N-2);
    assign accept    = samples.valid && samples.ready;
    assign t_on      = (lead_reg == r_eff);
    assign r_x       = ROW_W'(r_eff);
    assign h_x       = ROW_W'(h_eff);
    assign w_m1      = w_eff - WV_W'(1);
    assign out_en    = t_on && (trow_reg >= r_x);
    assign last      = t_on && (trow_reg == h_x - ROW_W'(1) + r_x)
                       && (WV_W'(tcol_reg) == w_m1);
    assign add_en    = trow_reg < h_x;
    assign sub_en    = trow_reg >= (r_x + r_x + ROW_W'(1));
    assign first_row = (trow_reg == '0);

    // counter next values
    always_comb
    begin
        pcol_next = pcol_reg;
        lead_next = lead_reg;
        tcol_next = tcol_reg;
        trow_next = trow_reg;
        slot_next = slot_reg;
        if (cfg_hit || (accept && last))
        begin
            pcol_next = '0;
            lead_next = '0;
            tcol_next = '0;
            trow_next = '0;
            slot_next = '0;
        end
        else if (accept)
        begin
            pcol_next = (WV_W'(pcol_reg) == w_m1) ? '0 : pcol_reg + COL_W'(1);
            if (!t_on)
                lead_next = lead_reg + R_W'(1);
            else if (WV_W'(tcol_reg) == w_m1)
            begin
                tcol_next = '0;
                trow_next = trow_reg + ROW_W'(1);
                slot_next = (SLOT_W'(slot_reg) == SLOT_W'({r_eff, 1'b0}))
                            ? '0 : slot_reg + SLOT_W'(1);
            end
            else
                tcol_next = tcol_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            lead_reg <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            pcol_reg <= pcol_next;
            lead_reg <= lead_next;
            tcol_reg <= tcol_next;
            trow_reg <= trow_next;
            slot_reg <= slot_next;
        end
    end

    // ---------------- horizontal sum from row prefix history ----------------
    // hist_reg[i] is the row prefix (mod 2^HW) of the item i positions back
    logic [HW-1:0]    hist_reg [1:HIST_N];
    logic [HW-1:0]    cur_pref, a_val, b_val, h_val;
    logic [SW-1:0]    x_val;
    logic [CI_W-1:0]  ci;
    logic [TAP_W-1:0] a_tap, b_tap;

    always_comb
    begin
        x_val    = samples.func ? '0 : samples.sample;
        cur_pref = ((pcol_reg == '0) ? '0 : hist_reg[1]) + {{(HW-SW){x_val[SW-1]}}, x_val};
        // right edge: window end clipped to the end of row t
        ci       = CI_W'(tcol_reg) + CI_W'(r_eff) + CI_W'(1);
        a_tap    = (ci > CI_W'(w_eff)) ? TAP_W'(ci - CI_W'(w_eff)) : '0;
        b_tap    = TAP_W'({r_eff, 1'b1});
        a_val    = (a_tap == '0) ? cur_pref : hist_reg[a_tap];
        b_val    = (CI_W'(tcol_reg) >= CI_W'(r_eff) + CI_W'(1)) ? hist_reg[b_tap] : '0;
        h_val    = a_val - b_val;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg[1] <= cur_pref;
            for (int i = 2; i <= HIST_N; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    // ---------------- memories ----------------
    logic [HW-1:0]    store_mem [0:ST_DEPTH-1];
    logic [SUM_W-1:0] col_mem   [0:MAX_WIDTH-1];
    logic [ADDR_W-1:0] st_addr;
    logic [HW-1:0]    st_rd_reg;
    logic [SUM_W-1:0] col_rd_reg;

    assign st_addr = {slot_reg, tcol_reg};

    // stage 1 registers
    logic              s1_last_reg, s1_add_reg, s1_sub_reg, s1_first_reg;
    logic              s1_cfwd_reg, s1_hfwd_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [HW-1:0]     s1_h_reg, s1_hfv_reg;
    logic [SUM_W-1:0]  s1_cfv_reg, c_val, colv;
    logic [HW-1:0]     oldh;

    // column update in stage 1
    always_comb
    begin
        colv  = s1_first_reg ? '0 : (s1_cfwd_reg ? s1_cfv_reg : col_rd_reg);
        oldh  = s1_sub_reg ? (s1_hfwd_reg ? s1_hfv_reg : st_rd_reg) : '0;
        c_val = colv + (s1_add_reg ? {{(SUM_W-HW){s1_h_reg[HW-1]}}, s1_h_reg} : '0)
                     - {{(SUM_W-HW){oldh[HW-1]}}, oldh};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_rd_reg  <= store_mem[st_addr];
            col_rd_reg <= col_mem[tcol_reg];
        end
        if (s1_valid_reg)
        begin
            store_mem[s1_addr_reg] <= s1_h_reg;
            col_mem[s1_col_reg]    <= c_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept && t_on;
    end

    // stage 1 payload, with forwarding for same-entry hits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_out_reg   <= out_en;
            s1_last_reg  <= last;
            s1_add_reg   <= add_en;
            s1_sub_reg   <= sub_en;
            s1_first_reg <= first_row;
            s1_col_reg   <= tcol_reg;
            s1_addr_reg  <= st_addr;
            s1_h_reg     <= h_val;
            s1_cfwd_reg  <= s1_valid_reg && (s1_col_reg == tcol_reg);
            s1_cfv_reg   <= c_val;
            s1_hfwd_reg  <= s1_valid_reg && (s1_addr_reg == st_addr);
            s1_hfv_reg   <= s1_h_reg;
        end
    end

    // ---------------- output buffer ----------------
    logic [SUM_W:0]   fifo_reg [0:FIFO_N-1];
    logic [FP_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic             push, pop;

    assign push          = s1_valid_reg && s1_out_reg;
    assign pop           = results.valid && results.ready;
    assign results.valid = (cnt_reg != '0);
    assign results.box_sum   = fifo_reg[rd_ptr_reg][SUM_W-1:0];
    assign results.frame_end = fifo_reg[rd_ptr_reg][SUM_W];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= {s1_last_reg, c_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FP_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FP_W'(1);
            cnt_reg <= cnt_reg + FC_W'(push) - FC_W'(pop);
        end
    end

endmodule

// ===== sv/bfws_checker.sv =====
// Port-level checks for box_filter_window_sum_core, attached by bind.
// Sees only the top level's ports; no package dependency.
module bfws_checker #(
    parameter int SUM_W = 27
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SUM_W-1:0] out_sum,
    input logic             out_end
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sum) && $stable(out_end))
        else $error("result payload changed while stalled");

    // input back-pressure only while results wait in the buffer
    a_ready_why: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // nothing offered while in reset
    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // a result never comes up without an input transaction that passed the stage 1 registers and the output buffer
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without cause");

endmodule

bind box_filter_window_sum_core bfws_checker #(.SUM_W(SUM_W)) u_bfws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_sum   (results.box_sum),
    .out_end   (results.frame_end)
);

// ===== tb/bfws_window_sum_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the box filter window sum block: watches both streams and the
// config port, predicts each window sum and compares it. Depends on bfws_pkg, bfws_if.
module bfws_window_sum_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    bfws_in_if                             samples,
    bfws_out_if                            results,
    input  logic                           cfg_we,
    input  logic [bfws_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bfws_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             sums_pending
);
    localparam int MAX_R      = 16;
    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int HIST_D     = 2 * MAX_R + 1;
    localparam int RING_D     = 2 * MAX_R * MAX_W + MAX_R + 1;

    typedef struct packed {
        logic signed [26:0] box_sum;
        logic               frame_end;
    } window_result_t;

    // predictor copy of the block's state
    logic [bfws_pkg::RADIUS_W-1:0] radius_q;
    logic [bfws_pkg::DIM_W-1:0]    width_q;
    logic [bfws_pkg::DIM_W-1:0]    height_q;
    int                            row_hist [HIST_D];
    int                            row_acc;
    int                            hsum_ring [RING_D];
    int                            taken_cnt;
    int                            given_cnt;
    window_result_t                sum_queue [$];

    assign sums_pending = sum_queue.size();

    function automatic void put_hsum(int row, int col, int w, int v);
        if (col >= 0)
            hsum_ring[(row * w + col) % RING_D] = v;
    endfunction

    // horizontal running sum of one sample, with row-end flush
    function automatic void push_sample(int pos, int x, int r, int w);
        int row;
        int c;
        int drop;
        row = pos / w;
        c   = pos % w;
        if (c == 0) row_acc = 0;
        row_acc += x;
        if (c - 2 * r - 1 >= 0) row_acc -= row_hist[(c - 2 * r - 1) % HIST_D];
        row_hist[c % HIST_D] = x;
        put_hsum(row, c - r, w, row_acc);
        if (c == w - 1) begin
            for (int k = 1; k <= r; k++) begin
                drop = c - 2 * r - 1 + k;
                if (drop >= 0) row_acc -= row_hist[drop % HIST_D];
                put_hsum(row, c - r + k, w, row_acc);
            end
        end
    endfunction

    // one transaction in; queue the window sum it releases, if any
    function automatic void predict_window(logic drain, logic signed [15:0] smp);
        int r;
        int w;
        int h;
        int total;
        int pos;
        int x;
        int hr;
        int wc;
        int lo;
        int hi;
        int acc;
        window_result_t res;
        r     = (radius_q > MAX_R) ? MAX_R : radius_q;
        w     = (width_q == 0) ? 1 : ((width_q > MAX_W) ? MAX_W : width_q);
        h     = (height_q == 0) ? 1 : ((height_q > MAX_H) ? MAX_H : height_q);
        total = w * h;
        pos   = taken_cnt;
        x     = drain ? 0 : int'(smp);
        if (pos < total) push_sample(pos, x, r, w);
        taken_cnt = pos + 1;
        if (pos >= r * w + r && given_cnt < total) begin
            hr  = given_cnt / w;
            wc  = given_cnt % w;
            lo  = (hr > r) ? hr - r : 0;
            hi  = (hr + r < h - 1) ? hr + r : h - 1;
            acc = 0;
            for (int j = lo; j <= hi; j++)
                acc += hsum_ring[(j * w + wc) % RING_D];
            given_cnt++;
            res.box_sum   = acc[26:0];
            res.frame_end = (given_cnt == total);
            if (res.frame_end) begin
                taken_cnt = 0;
                given_cnt = 0;
            end
            sum_queue.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t exp_res;
        if (!rst_n) begin
            radius_q   = bfws_pkg::RADIUS_RST;
            width_q    = bfws_pkg::WIDTH_RST;
            height_q   = bfws_pkg::HEIGHT_RST;
            row_acc    = 0;
            taken_cnt  = 0;
            given_cnt  = 0;
            fail_count = 0;
            foreach (row_hist[i]) row_hist[i] = 0;
            sum_queue.delete();
        end else begin
            // register writes restart the frame
            if (cfg_we) begin
                case (bfws_pkg::cfg_reg_t'(cfg_addr))
                    bfws_pkg::REG_RADIUS: radius_q = cfg_data[bfws_pkg::RADIUS_W-1:0];
                    bfws_pkg::REG_WIDTH:  width_q  = cfg_data;
                    bfws_pkg::REG_HEIGHT: height_q = cfg_data;
                    default: ;
                endcase
                if (bfws_pkg::cfg_reg_t'(cfg_addr) inside {bfws_pkg::REG_RADIUS,
                        bfws_pkg::REG_WIDTH, bfws_pkg::REG_HEIGHT}) begin
                    taken_cnt = 0;
                    given_cnt = 0;
                    row_acc   = 0;
                end
            end
            // result side first: a new prediction cannot leave in the same cycle
            if (results.valid && results.ready) begin
                if (sum_queue.size() == 0) begin
                    $error("unexpected result transaction: box_sum %0d", results.box_sum);
                    fail_count++;
                end else begin
                    exp_res = sum_queue.pop_front();
                    if (results.box_sum !== exp_res.box_sum) begin
                        $error("box_sum: expected %0d, actual %0d",
                               exp_res.box_sum, results.box_sum);
                        fail_count++;
                    end
                    if (results.frame_end !== exp_res.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               exp_res.frame_end, results.frame_end);
                        fail_count++;
                    end
                end
            end
            if (samples.valid && samples.ready)
                predict_window(samples.func, samples.sample);
        end
    end
endmodule

// ===== tb/tb_box_filter_window_sum_core.sv =====
`timescale 1ns / 100ps
// Top of the box filter window sum testbench: clock, reset, config sweep and
// frame stimulus, receiver stalls, watchdog and verdict. Depends on bfws_pkg,
// bfws_if, box_filter_window_sum_core and bfws_window_sum_checker.
module tb_box_filter_window_sum_core;

    localparam int IDLE_LIMIT = 3000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bfws_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [bfws_pkg::CFG_DAT_W-1:0] cfg_data;
    int                             fail_count;
    int                             sums_pending;
    int                             items_sent;
    int                             idle_cycles;
    int                             burst_left;
    logic                           hold_go;

    bfws_in_if          samples ();
    bfws_out_if #(27)   results ();

    box_filter_window_sum_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .results  (results),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    bfws_window_sum_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .results      (results),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .sums_pending (sums_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random choice among stall modes, plus one long hold-off
    initial
    begin
        int  cyc;
        int  mode;
        bit  held;
        cyc  = 0;
        mode = 0;
        held = 0;
        results.ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 200 == 0) mode = $urandom_range(0, 3);
            if (hold_go && !held) begin
                held = 1;
                results.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            case (mode)
                0:       results.ready <= 1'b1;
                1:       results.ready <= (cyc % 5) < 3;
                2:       results.ready <= ($urandom_range(0, 9) < 7);
                default: results.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // watchdog on cycles with no transaction on either stream
    initial
    begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one input transaction, sender bursts and gaps included
    task automatic send_item(input logic drain, input logic [15:0] smp);
        if (burst_left == 0) begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(3, 12) : $urandom_range(1, 2))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        samples.valid  <= 1'b1;
        samples.func   <= drain;
        samples.sample <= smp;
        do @(posedge clk); while (!samples.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // one register write, after which cfg_we is released
    task automatic write_reg(input bfws_pkg::cfg_reg_t idx, input int val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[bfws_pkg::CFG_DAT_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // wait until the block is drained, then program a new frame shape
    task automatic set_shape(input int r_val, input int w_val, input int h_val);
        samples.valid <= 1'b0;
        @(negedge clk);
        while (sums_pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        write_reg(bfws_pkg::REG_RADIUS, r_val);
        write_reg(bfws_pkg::REG_WIDTH, w_val);
        write_reg(bfws_pkg::REG_HEIGHT, h_val);
    endtask

    // fill: 0 random with odd drains inside, 1 all max, 2 all min; odd samples in tail
    task automatic run_frame(input int r_val, input int w_val, input int h_val,
                             input int fill);
        int r;
        int w;
        int h;
        logic [15:0] v;
        r = (r_val > 16) ? 16 : r_val;
        w = (w_val == 0) ? 1 : ((w_val > 1024) ? 1024 : w_val);
        h = (h_val == 0) ? 1 : ((h_val > 1024) ? 1024 : h_val);
        set_shape(r_val, w_val, h_val);
        for (int i = 0; i < w * h; i++) begin
            v = (fill == 1) ? 16'h7fff : ((fill == 2) ? 16'h8000 : 16'($urandom));
            send_item(fill == 0 && $urandom_range(0, 19) == 0, v);
        end
        for (int i = 0; i < r * w + r; i++)
            send_item($urandom_range(0, 3) != 0, 16'($urandom));
    endtask

    initial
    begin
        int rr;
        int ww;
        int hh;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = bfws_pkg::REG_RADIUS;
        cfg_data       = '0;
        samples.valid  = 1'b0;
        samples.func   = 1'b0;
        samples.sample = '0;
        hold_go        = 1'b0;
        items_sent     = 0;
        burst_left     = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: sample extremes, tiny frames, window larger than the frame
        run_frame(1, 3, 3, 1);
        run_frame(0, 1, 1, 2);
        run_frame(2, 2, 2, 2);

        // register extremes and out-of-range values
        run_frame(16, 1, 1, 0);
        run_frame(31, 0, 0, 0);
        run_frame(0, 40, 2, 0);
        run_frame(1, 1, 30, 0);
        hold_go = 1'b1;
        run_frame(2, 40, 4, 1);
        run_frame(3, 5, 12, 0);

        // random small frames
        while (items_sent < 800) begin
            rr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
            ww = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            run_frame(rr, ww, hh, 0);
        end

        samples.valid <= 1'b0;
        while (sums_pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
